### rtl/core/dav_pkg.sv
`timescale 1ns / 1ps

package dav_pkg;

  localparam int ANGLE_W    = 16;
  localparam int FRAC_BITS  = 8;
  localparam int SCALE_W    = 10;
  localparam int READ_W     = 18;
  localparam int WIN_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Divisor and remainder hold up to one full turn, so one bit above the angle.
  localparam int DIVR_W = ANGLE_W + 1;
  // Every quotient the block needs (reading and average) fits in a reading.
  localparam int QUO_W  = READ_W;

  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_ANGLE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CALIBRATED  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 3'd5;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd8;

  typedef struct packed {
    logic              start;
    logic [DIVR_W-1:0] hi;
    logic [QUO_W-1:0]  lo;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

endpackage

### rtl/core/dav_ram.sv
`timescale 1ns / 1ps

module dav_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### rtl/core/dav_div.sv
`timescale 1ns / 1ps

module dav_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dav_pkg::div_req_t          req,
  output logic                       done,
  output logic [dav_pkg::QUO_W-1:0]  quotient,
  output logic [dav_pkg::DIVR_W-1:0] remainder
);

  import dav_pkg::*;

  localparam int STEP_W = $clog2(QUO_W);

  logic [DIVR_W-1:0] rem_r;
  logic [QUO_W-1:0]  quo_r;
  logic [DIVR_W-1:0] div_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;

  logic [DIVR_W:0]   trial;
  logic              fits;
  logic [DIVR_W:0]   rem_nxt;

  // One restoring step: bring down the next dividend bit and try the divisor.
  always_comb begin
    trial   = {rem_r, quo_r[QUO_W-1]};
    fits    = trial >= {1'b0, div_r};
    rem_nxt = fits ? (trial - {1'b0, div_r}) : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The upper dividend part is always below the divisor, so QUO_W steps suffice.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.hi;
      quo_r <= req.lo;
      div_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt[DIVR_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], fits};
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

### rtl/core/dial_angle_to_value_smoother.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_needle_angle, in_angle_present
// out      output     out_valid / out_ready  out_reading, out_reading_valid,
//                                            out_smoothed, out_smoothed_valid
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A word with a reading inside the arc runs the divider for the reading; a full-scale
// reading skips that division, and the average division is skipped with an empty history.
// The shared divider makes one quotient bit per cycle and is run at most once for the
// reading and once for the average.
// Reset is synchronous and active low; the history memory is not cleared.
// One result waits in the output register; a second one holds the input off.

module dial_angle_to_value_smoother #(
  parameter int HISTORY_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dav_pkg::ANGLE_W-1:0]    in_needle_angle,
  input  logic                           in_angle_present,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dav_pkg::READ_W-1:0]     out_reading,
  output logic                           out_reading_valid,
  output logic [dav_pkg::READ_W-1:0]     out_smoothed,
  output logic                           out_smoothed_valid,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dav_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dav_pkg::CFG_DATA_W-1:0] cfg_data
);

  import dav_pkg::*;

  localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W = READ_W + CNT_W;
  localparam int PROD_W = ANGLE_W + SCALE_W;
  localparam int NUM_W  = PROD_W + FRAC_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MAP    = 3'd1;
  localparam logic [2:0] S_RDIV   = 3'd2;
  localparam logic [2:0] S_PUSH   = 3'd3;
  localparam logic [2:0] S_ASTART = 3'd4;
  localparam logic [2:0] S_ADIV   = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]         state_r;

  logic [ANGLE_W-1:0] start_r;
  logic [ANGLE_W-1:0] end_r;
  logic [SCALE_W-1:0] min_r;
  logic [SCALE_W-1:0] max_r;
  logic               cal_r;
  logic [WIN_W-1:0]   window_r;

  logic [ANGLE_W-1:0] needle_r;
  logic               present_r;
  logic               rising_r;
  logic [READ_W-1:0]  reading_r;
  logic               rvalid_r;
  logic [READ_W-1:0]  smooth_r;
  logic               svalid_r;

  logic [PTR_W-1:0]   wp_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SUM_W-1:0]   sum_r;

  logic               out_valid_r;
  logic [READ_W-1:0]  out_reading_r;
  logic               out_rvalid_r;
  logic [READ_W-1:0]  out_smooth_r;
  logic               out_svalid_r;

  logic [CNT_W-1:0]   w_eff;
  logic [ANGLE_W-1:0] off;
  logic [ANGLE_W-1:0] arc_raw;
  logic [DIVR_W-1:0]  arc;
  logic               in_arc;
  logic               rising;
  logic [SCALE_W-1:0] diff;
  logic [PROD_W-1:0]  prod;
  logic [NUM_W-1:0]   num;
  logic               go_div;
  logic               full_scale;
  logic [READ_W-1:0]  base;
  logic [READ_W-1:0]  mapped;
  logic               full;
  logic [SUM_W-1:0]   sum_nxt;
  logic [CNT_W-1:0]   wp_inc;
  logic               win_write;

  div_req_t           div_req;
  logic               div_done;
  logic [QUO_W-1:0]   div_quo;
  logic [DIVR_W-1:0]  div_rem;
  logic [READ_W-1:0]  ring_rdata;

  always_comb begin
    if (window_r == '0) begin
      w_eff = CNT_W'(1);
    end else if (int'(window_r) > HISTORY_DEPTH) begin
      w_eff = CNT_W'(HISTORY_DEPTH);
    end else begin
      w_eff = CNT_W'(window_r);
    end
  end

  // Mapping of the needle onto the arc; an equal start and end is a full turn.
  always_comb begin
    off        = needle_r - start_r;
    arc_raw    = end_r - start_r;
    arc        = (arc_raw == '0) ? {1'b1, ANGLE_W'(0)} : {1'b0, arc_raw};
    in_arc     = {1'b0, off} <= arc;
    rising     = max_r >= min_r;
    diff       = rising ? (max_r - min_r) : (min_r - max_r);
    prod       = PROD_W'(off) * PROD_W'(diff);
    num        = NUM_W'(prod) << FRAC_BITS;
    go_div     = cal_r && present_r && in_arc;
    full_scale = cal_r && present_r && !in_arc && (end_r > start_r);
    base       = READ_W'(min_r) << FRAC_BITS;
  end

  // A falling scale rounds the subtracted part up, so the reading is still floored.
  always_comb begin
    if (rising_r) begin
      mapped = base + div_quo;
    end else begin
      mapped = base - div_quo - READ_W'(div_rem != '0);
    end
  end

  always_comb begin
    full    = cnt_r >= w_eff;
    sum_nxt = full ? (sum_r - SUM_W'(ring_rdata) + SUM_W'(reading_r))
                   : (sum_r + SUM_W'(reading_r));
    wp_inc  = CNT_W'(wp_r) + CNT_W'(1);
  end

  always_comb begin
    div_req.start   = 1'b0;
    div_req.hi      = DIVR_W'(num[NUM_W-1:QUO_W]);
    div_req.lo      = num[QUO_W-1:0];
    div_req.divisor = arc;
    if (state_r == S_MAP) begin
      div_req.start = go_div;
    end else if (state_r == S_ASTART) begin
      div_req.start   = cnt_r != '0;
      div_req.hi      = DIVR_W'(sum_r[SUM_W-1:READ_W]);
      div_req.lo      = sum_r[READ_W-1:0];
      div_req.divisor = DIVR_W'(cnt_r);
    end
  end

  assign win_write = cfg_valid && cfg_ready && (cfg_index == REG_WINDOW_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= '0;
      end_r    <= '0;
      min_r    <= '0;
      max_r    <= '0;
      cal_r    <= 1'b0;
      window_r <= WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_START_ANGLE: start_r  <= cfg_data[ANGLE_W-1:0];
        REG_END_ANGLE:   end_r    <= cfg_data[ANGLE_W-1:0];
        REG_SCALE_MIN:   min_r    <= cfg_data[SCALE_W-1:0];
        REG_SCALE_MAX:   max_r    <= cfg_data[SCALE_W-1:0];
        REG_CALIBRATED:  cal_r    <= cfg_data[0];
        REG_WINDOW_LEN:  window_r <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_MAP;
          end
        end
        S_MAP: begin
          if (go_div) begin
            state_r <= S_RDIV;
          end else if (full_scale) begin
            state_r <= S_PUSH;
          end else begin
            state_r <= S_ASTART;
          end
        end
        S_RDIV: begin
          if (div_done) begin
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!full) begin
            cnt_r <= cnt_r + 1'b1;
          end
          sum_r   <= sum_nxt;
          wp_r    <= (wp_inc >= w_eff) ? '0 : PTR_W'(wp_inc);
          state_r <= S_ASTART;
        end
        S_ASTART: begin
          state_r <= (cnt_r == '0) ? S_OUT : S_ADIV;
        end
        S_ADIV: begin
          if (div_done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      // Changing the window restarts the history.
      if (win_write) begin
        wp_r  <= '0;
        cnt_r <= '0;
        sum_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      needle_r  <= in_needle_angle;
      present_r <= in_angle_present;
    end
    if (state_r == S_MAP) begin
      rising_r  <= rising;
      rvalid_r  <= go_div || full_scale;
      reading_r <= full_scale ? (READ_W'(max_r) << FRAC_BITS) : '0;
    end
    if (state_r == S_RDIV && div_done) begin
      reading_r <= mapped;
    end
    if (state_r == S_ASTART) begin
      smooth_r <= '0;
      svalid_r <= cnt_r != '0;
    end
    if (state_r == S_ADIV && div_done) begin
      smooth_r <= div_quo;
    end
    if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
      out_reading_r <= reading_r;
      out_rvalid_r  <= rvalid_r;
      out_smooth_r  <= smooth_r;
      out_svalid_r  <= svalid_r;
    end
  end

  dav_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (div_req),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // The read port follows the write pointer, so the entry to be replaced is
  // already on the read data when the new reading is written.
  dav_ram #(
    .WIDTH (READ_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (state_r == S_PUSH && !win_write),
    .waddr (wp_r),
    .wdata (reading_r),
    .raddr (wp_r),
    .rdata (ring_rdata)
  );

  assign in_ready           = state_r == S_IDLE;
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_reading        = out_reading_r;
  assign out_reading_valid  = out_rvalid_r;
  assign out_smoothed       = out_smooth_r;
  assign out_smoothed_valid = out_svalid_r;

  a_count_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= w_eff)
    else $error("stored count exceeds the averaging window");

  a_pointer_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(wp_r) < w_eff)
    else $error("write pointer outside the averaging window");

  a_empty_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (sum_r == '0))
    else $error("running sum nonzero with empty history");

  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_RDIV || state_r == S_ADIV))
    else $error("divider finished while no division was awaited");

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |=> !div_done)
    else $error("divider finished right after a start");

endmodule
